@@ design/marked_record_table_compactor_macros.svh @@
// assertion macros for the marked record table compactor
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef MARKED_RECORD_TABLE_COMPACTOR_MACROS_SVH
`define MARKED_RECORD_TABLE_COMPACTOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MRTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mrtc_pkg.sv @@
// shared types and constants for the marked record table compactor
// no dependencies
package mrtc_pkg;

    // field widths
    localparam int CLASS_W   = 4;
    localparam int BAND_W    = 8;
    localparam int SLOT_W    = 11;
    localparam int WORD_W    = 64;
    // payload words carried on the ports besides the energy word
    localparam int IN_PWORDS = 4;

    // default sizing
    localparam int CAPACITY_DEF      = 1024;
    localparam int PAYLOAD_WORDS_DEF = 4;

    // class code that marks a record dead
    localparam logic [CLASS_W-1:0] DEAD_CLASS = 4'd9;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_COMPACT = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_C_RD_I,
        S_C_CHK_I,
        S_C_RD_TOP,
        S_C_CHK_TOP,
        S_C_MARK,
        S_T_RD,
        S_T_CHK,
        S_DONE
    } t_state;

endpackage

@@ design/marked_record_table_compactor.sv @@
// marked record table compactor: record table in one synchronous memory plus sequencer
// depends on mrtc_pkg and marked_record_table_compactor_macros.svh
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------
// in        | input     | i_in_valid / o_in_ready   | action, slot, record fields
// out       | output    | o_out_valid / i_out_ready | record fields, used count
//
// load, read and no-op: the item passes through S_DONE, and a new item is only taken once
// its result is in the output register. compact: scans each index, probes top entries,
// moves a live top record down into each dead hole and marks the source dead, then trims
// dead entries off the top; every probe uses the single registered read port of the memory.
// reset clears the count and the control state; the memory needs no clearing.
// a new item is taken while the last result waits; the block then holds its result
// until the output register is free.
`include "marked_record_table_compactor_macros.svh"

module marked_record_table_compactor #(
    parameter int CAPACITY      = mrtc_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WORDS = mrtc_pkg::PAYLOAD_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic [mrtc_pkg::SLOT_W-1:0]       i_slot,
    input  logic [mrtc_pkg::CLASS_W-1:0]      i_class_code,
    input  logic [mrtc_pkg::BAND_W-1:0]       i_band,
    input  logic [mrtc_pkg::WORD_W-1:0]       i_energy_word,
    input  logic [mrtc_pkg::WORD_W-1:0]       i_momentum_word,
    input  logic [mrtc_pkg::WORD_W-1:0]       i_position_word,
    input  logic [mrtc_pkg::WORD_W-1:0]       i_flight_word,
    input  logic [mrtc_pkg::WORD_W-1:0]       i_region_word,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mrtc_pkg::CLASS_W-1:0]      o_class_out,
    output logic [mrtc_pkg::BAND_W-1:0]       o_band_out,
    output logic [mrtc_pkg::WORD_W-1:0]       o_energy_out,
    output logic [mrtc_pkg::WORD_W-1:0]       o_momentum_out,
    output logic [mrtc_pkg::WORD_W-1:0]       o_position_out,
    output logic [mrtc_pkg::WORD_W-1:0]       o_flight_out,
    output logic [mrtc_pkg::WORD_W-1:0]       o_region_out,
    output logic [mrtc_pkg::SLOT_W-1:0]       o_used_count
);

    localparam int WORD_W  = mrtc_pkg::WORD_W;
    localparam int CLASS_W = mrtc_pkg::CLASS_W;
    localparam int BAND_W  = mrtc_pkg::BAND_W;
    localparam int SLOT_W  = mrtc_pkg::SLOT_W;
    localparam int NPW     = mrtc_pkg::IN_PWORDS;
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 2);
    localparam int CMP_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    // record layout: class, band, then energy word (word 0) and payload words
    localparam int REC_W   = CLASS_W + BAND_W + WORD_W * (PAYLOAD_WORDS + 1);

    // record memory
    logic [REC_W-1:0] r_mem [CAPACITY];
    logic [REC_W-1:0] r_rdata;
    logic             mem_we;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [REC_W-1:0] mem_wdata;

    // control state
    mrtc_pkg::t_state  r_state, n_state;
    mrtc_pkg::t_action r_action, n_action;
    logic              r_ok, n_ok;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_top, n_top;
    logic [CNT_W-1:0]  r_n, n_n;

    // output register
    logic                 r_o_valid, n_o_valid;
    logic                 load_out;
    logic [CLASS_W-1:0]   r_o_class;
    logic [BAND_W-1:0]    r_o_band;
    logic [WORD_W-1:0]    r_o_word [NPW+1];
    logic [SLOT_W-1:0]    r_o_count;

    // slot decode
    logic [CMP_W-1:0]  slot_ext;
    logic [CMP_W-1:0]  slot_m1;
    logic              slot_ok;
    logic [CMP_W-1:0]  count_ext;
    logic              in_xfer;
    mrtc_pkg::t_action in_action;

    assign o_in_ready = (r_state == mrtc_pkg::S_IDLE);
    assign slot_ext  = CMP_W'(i_slot);
    assign slot_m1   = slot_ext - CMP_W'(1);
    assign slot_ok   = (i_slot != '0) && (slot_ext <= CMP_W'(CAPACITY));
    assign count_ext = CMP_W'(r_count);
    assign in_xfer   = i_in_valid && o_in_ready;
    assign in_action = mrtc_pkg::t_action'(i_action);

    // counter to memory address, entries are 1-based
    logic [CNT_W-1:0] i_m1, top_m1, n_m1;
    assign i_m1   = r_i - CNT_W'(1);
    assign top_m1 = r_top - CNT_W'(1);
    assign n_m1   = r_n - CNT_W'(1);

    // record built from the input fields
    logic [WORD_W-1:0] in_words [NPW+1];
    logic [REC_W-1:0]  ld_rec;
    assign in_words[0] = i_energy_word;
    assign in_words[1] = i_momentum_word;
    assign in_words[2] = i_position_word;
    assign in_words[3] = i_flight_word;
    assign in_words[4] = i_region_word;
    assign ld_rec[REC_W-1 -: CLASS_W]          = i_class_code;
    assign ld_rec[REC_W-CLASS_W-1 -: BAND_W]   = i_band;

    genvar k;
    generate
        for (k = 0; k <= PAYLOAD_WORDS; k++) begin : g_ld_word
            if (k <= NPW) begin : g_in
                assign ld_rec[k*WORD_W +: WORD_W] = in_words[k];
            end else begin : g_zero
                assign ld_rec[k*WORD_W +: WORD_W] = '0;
            end
        end
    endgenerate

    // record fields of the read data, zero beyond the stored words
    logic [WORD_W-1:0] rd_words [NPW+1];
    generate
        for (k = 0; k <= NPW; k++) begin : g_rd_word
            if (k <= PAYLOAD_WORDS) begin : g_mem
                assign rd_words[k] = r_rdata[k*WORD_W +: WORD_W];
            end else begin : g_zero
                assign rd_words[k] = '0;
            end
        end
    endgenerate

    logic rd_dead;
    logic rec_sel;
    assign rd_dead = (r_rdata[REC_W-1 -: CLASS_W] == mrtc_pkg::DEAD_CLASS);
    assign rec_sel = (r_action == mrtc_pkg::ACT_READ) && r_ok;

    // sequencer: next state and memory controls
    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_ok      = r_ok;
        n_count   = r_count;
        n_i       = r_i;
        n_top     = r_top;
        n_n       = r_n;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = slot_m1[ADDR_W-1:0];
        mem_raddr = slot_m1[ADDR_W-1:0];
        mem_wdata = ld_rec;
        load_out  = 1'b0;

        unique case (r_state)
            mrtc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_action = in_action;
                    n_ok     = slot_ok;
                    n_state  = mrtc_pkg::S_DONE;
                    unique case (in_action)
                        mrtc_pkg::ACT_LOAD: begin
                            mem_we = slot_ok;
                            if (slot_ok && (slot_ext > count_ext)) begin
                                n_count = slot_ext[CNT_W-1:0];
                            end
                        end
                        mrtc_pkg::ACT_READ: begin
                            mem_re = slot_ok;
                        end
                        mrtc_pkg::ACT_COMPACT: begin
                            n_i     = CNT_W'(1);
                            n_top   = r_count;
                            n_n     = r_count;
                            n_state = mrtc_pkg::S_C_RD_I;
                        end
                        mrtc_pkg::ACT_NONE: begin
                        end
                    endcase
                end
            end
            // fetch the low entry while it is within the count and an entry remains above it
            mrtc_pkg::S_C_RD_I: begin
                if ((r_i <= r_n) && (r_top > r_i)) begin
                    mem_re    = 1'b1;
                    mem_raddr = i_m1[ADDR_W-1:0];
                    n_state   = mrtc_pkg::S_C_CHK_I;
                end else begin
                    n_state = mrtc_pkg::S_T_RD;
                end
            end
            mrtc_pkg::S_C_CHK_I: begin
                if (rd_dead) begin
                    n_state = mrtc_pkg::S_C_RD_TOP;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = mrtc_pkg::S_C_RD_I;
                end
            end
            // walk down from the top looking for a live record
            mrtc_pkg::S_C_RD_TOP: begin
                if (r_top > r_i) begin
                    mem_re    = 1'b1;
                    mem_raddr = top_m1[ADDR_W-1:0];
                    n_state   = mrtc_pkg::S_C_CHK_TOP;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = mrtc_pkg::S_C_RD_I;
                end
            end
            mrtc_pkg::S_C_CHK_TOP: begin
                if (rd_dead) begin
                    n_top   = r_top - CNT_W'(1);
                    n_state = mrtc_pkg::S_C_RD_TOP;
                end else begin
                    // move the live top record down into the hole
                    mem_we    = 1'b1;
                    mem_waddr = i_m1[ADDR_W-1:0];
                    mem_wdata = r_rdata;
                    n_state   = mrtc_pkg::S_C_MARK;
                end
            end
            // mark the moved source dead, read data still holds it
            mrtc_pkg::S_C_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = top_m1[ADDR_W-1:0];
                mem_wdata = {mrtc_pkg::DEAD_CLASS, r_rdata[REC_W-CLASS_W-1:0]};
                n_top     = r_top - CNT_W'(1);
                n_i       = r_i + CNT_W'(1);
                n_state   = mrtc_pkg::S_C_RD_I;
            end
            // trim dead entries off the top
            mrtc_pkg::S_T_RD: begin
                if (r_n == '0) begin
                    n_count = r_n;
                    n_state = mrtc_pkg::S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = n_m1[ADDR_W-1:0];
                    n_state   = mrtc_pkg::S_T_CHK;
                end
            end
            mrtc_pkg::S_T_CHK: begin
                if (rd_dead) begin
                    n_n     = r_n - CNT_W'(1);
                    n_state = mrtc_pkg::S_T_RD;
                end else begin
                    n_count = r_n;
                    n_state = mrtc_pkg::S_DONE;
                end
            end
            // hand the result to the output register once it is free
            mrtc_pkg::S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = mrtc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrtc_pkg::S_IDLE;
            end
        endcase

        // output valid follows result loads and transfers
        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // record memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrtc_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // sequencer working registers
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_ok     <= n_ok;
        r_i      <= n_i;
        r_top    <= n_top;
        r_n      <= n_n;
    end

    // output payload register
    logic [CMP_W-1:0] count_out_ext;
    assign count_out_ext = CMP_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_class <= rec_sel ? r_rdata[REC_W-1 -: CLASS_W] : '0;
            r_o_band  <= rec_sel ? r_rdata[REC_W-CLASS_W-1 -: BAND_W] : '0;
            for (int w = 0; w <= NPW; w++) begin
                r_o_word[w] <= rec_sel ? rd_words[w] : '0;
            end
            r_o_count <= count_out_ext[SLOT_W-1:0];
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_class_out    = r_o_class;
    assign o_band_out     = r_o_band;
    assign o_energy_out   = r_o_word[0];
    assign o_momentum_out = r_o_word[1];
    assign o_position_out = r_o_word[2];
    assign o_flight_out   = r_o_word[3];
    assign o_region_out   = r_o_word[4];
    assign o_used_count   = r_o_count;

    // checks on the sequencer
    `MRTC_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `MRTC_ASSERT_NOW(a_mark_above, r_state == mrtc_pkg::S_C_MARK, r_top > r_i, "mark below hole")
    `MRTC_ASSERT_NOW(a_trim_bound, r_state == mrtc_pkg::S_T_RD, r_n <= r_count,
        "trim above count")
    `MRTC_ASSERT_NEXT(a_compact_keeps, (r_state == mrtc_pkg::S_C_RD_I) && (r_i > r_n),
        r_count == $past(r_count), "count moved during scan")

endmodule
